>>> rtl/core/ksd_pkg.sv
// Shared types, constants and helpers for the key sequence detector.
package ksd_pkg;

  // Limits of the code and digit phases
  localparam int unsigned MAX_CODE_LENGTH = 8;
  localparam int unsigned MAX_DIGITS      = 2;

  localparam int unsigned KEY_W   = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CODE_W  = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned DIGW_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CHARS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_ECHO = 3'd4;

  // Reset values of the registers
  localparam logic [LEN_W-1:0] CODE_LENGTH_RST   = 4'd1;
  localparam logic [TMO_W-1:0] TIMEOUT_TICKS_RST = 16'd70;

  // ASCII ranges
  localparam logic [KEY_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [KEY_W-1:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [KEY_W-1:0] ASCII_CASE    = 8'h20;
  localparam logic [KEY_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [KEY_W-1:0] ASCII_NINE    = 8'h39;

  typedef struct packed {
    logic [CODE_W-1:0] code_chars;
    logic [LEN_W-1:0]  code_length;
    logic [CNT_W-1:0]  digit_count;
    logic [TMO_W-1:0]  timeout_ticks;
    logic              suppress_echo;
  } ksd_cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]            code_progress;
    logic [CNT_W-1:0]            digit_progress;
    logic [1:0][KEY_W-1:0]       digit_store;
    logic [TIME_W-1:0]           last_key_time;
  } ksd_state_t;

  typedef struct packed {
    logic              matched;
    logic [DIGW_W-1:0] param_digits;
    logic              echo_valid;
    logic [KEY_W-1:0]  echo_key;
  } ksd_result_t;

  // Fold lowercase ASCII letters to uppercase
  function automatic logic [KEY_W-1:0] upcase(input logic [KEY_W-1:0] c);
    logic [KEY_W-1:0] r;
    r = c;
    if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
      r = c - ASCII_CASE;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ksd_step.sv
// Per-key next-state and result logic of the key sequence detector.
module ksd_step
  import ksd_pkg::*;
(
  input  ksd_cfg_t          cfg,
  input  ksd_state_t        st,
  input  logic [KEY_W-1:0]  key,
  input  logic [TIME_W-1:0] now,
  output ksd_state_t        st_nxt,
  output ksd_result_t       res
);

  logic [LEN_W-1:0]  len;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] gap;
  logic              timed_out;
  logic [LEN_W-1:0]  cp;
  logic [CNT_W-1:0]  dp;
  logic [KEY_W-1:0]  kup;
  logic [KEY_W-1:0]  exp_char;
  logic              aborted;
  logic [1:0][KEY_W-1:0] store;

  always_comb begin
    // Clamp the configured code length and digit count
    len = cfg.code_length;
    if (len == '0) begin
      len = LEN_W'(1);
    end else if (len > LEN_W'(MAX_CODE_LENGTH)) begin
      len = LEN_W'(MAX_CODE_LENGTH);
    end
    cnt = cfg.digit_count;
    if (cnt > CNT_W'(MAX_DIGITS)) begin
      cnt = CNT_W'(MAX_DIGITS);
    end

    // Inter-key timeout clears progress before the key is handled
    gap       = now - st.last_key_time;
    timed_out = (st.last_key_time != '0) && (gap > {{(TIME_W-TMO_W){1'b0}}, cfg.timeout_ticks});
    cp        = timed_out ? '0 : st.code_progress;
    dp        = timed_out ? '0 : st.digit_progress;

    kup      = upcase(key);
    exp_char = upcase(cfg.code_chars[{cp[2:0], 3'b000} +: KEY_W]);
    store    = st.digit_store;
    aborted  = 1'b0;
    res      = '0;

    if (cp < len) begin
      // Code phase: advance, or restart on a wrong key
      if (kup == exp_char) begin
        cp = cp + LEN_W'(1);
      end else begin
        cp = (kup == upcase(cfg.code_chars[KEY_W-1:0])) ? LEN_W'(1) : '0;
      end
      dp = '0;
      if (cp > LEN_W'(1) && !cfg.suppress_echo) begin
        res.echo_valid = 1'b1;
        res.echo_key   = key;
      end
    end else if (dp < cnt) begin
      // Digit phase: capture a decimal digit, abort on anything else
      if (key < ASCII_ZERO || key > ASCII_NINE) begin
        aborted = 1'b1;
      end else begin
        store[dp[0]] = key;
        dp = dp + CNT_W'(1);
      end
    end

    st_nxt.digit_store    = store;
    st_nxt.code_progress  = cp;
    st_nxt.digit_progress = dp;
    st_nxt.last_key_time  = now;

    if (aborted) begin
      st_nxt.code_progress  = '0;
      st_nxt.digit_progress = '0;
      st_nxt.last_key_time  = '0;
    end else if (cp >= len && dp >= cnt) begin
      // Full match: report digits, clear progress, keep the store
      st_nxt.code_progress  = '0;
      st_nxt.digit_progress = '0;
      st_nxt.last_key_time  = '0;
      res.matched = 1'b1;
      if (cnt >= CNT_W'(1)) begin
        res.param_digits[KEY_W-1:0] = store[0];
      end
      if (cnt >= CNT_W'(2)) begin
        res.param_digits[DIGW_W-1:KEY_W] = store[1];
      end
    end
  end

endmodule

>>> rtl/core/key_sequence_detector_unit.sv
// Top level of the key sequence detector: registers, pipeline and handshakes.
//
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_ready     | in_key, in_current_time
//  out_    | output    | out_valid / out_ready   | out_matched, out_param_digits,
//          |           |                         | out_echo_valid, out_echo_key
//  cfg_    | input     | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// One key per cycle sustained while out_ready stays high; a key passes through the
// input register, then the detector update into the result register.
// The detector state updates as a key moves from the input register to the
// result register, so back-to-back keys see each other's effects in order.
// Synchronous active-low reset clears state and both stages and loads the register reset values.
// A stalled result holds both stages; in_ready drops only when both are full.
module key_sequence_detector_unit
  import ksd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [TIME_W-1:0]    in_current_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_matched,
  output logic [DIGW_W-1:0]    out_param_digits,
  output logic                 out_echo_valid,
  output logic [KEY_W-1:0]     out_echo_key,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_wdata
);

  ksd_cfg_t          cfg_r;
  ksd_state_t        st_r;
  ksd_state_t        st_nxt;
  ksd_result_t       res_nxt;
  ksd_result_t       res_r;
  logic              s1_valid_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic [TIME_W-1:0] s1_time_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_xfer;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_chars    <= '0;
      cfg_r.code_length   <= CODE_LENGTH_RST;
      cfg_r.digit_count   <= '0;
      cfg_r.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg_r.suppress_echo <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODE_CHARS:    cfg_r.code_chars    <= cfg_wdata;
        REG_CODE_LENGTH:   cfg_r.code_length   <= cfg_wdata[LEN_W-1:0];
        REG_DIGIT_COUNT:   cfg_r.digit_count   <= cfg_wdata[CNT_W-1:0];
        REG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_wdata[TMO_W-1:0];
        REG_SUPPRESS_ECHO: cfg_r.suppress_echo <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_key_r  <= in_key;
      s1_time_r <= in_current_time;
    end
  end

  ksd_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .key    (s1_key_r),
    .now    (s1_time_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Detector state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matched      = res_r.matched;
  assign out_param_digits = res_r.param_digits;
  assign out_echo_valid   = res_r.echo_valid;
  assign out_echo_key     = res_r.echo_key;

endmodule

>>> rtl/core/ksd_checker.sv
// Port-level checks for the key sequence detector, bound to the top level.
module ksd_checker
  import ksd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_matched,
  input logic [DIGW_W-1:0] out_param_digits,
  input logic              out_echo_valid,
  input logic [KEY_W-1:0]  out_echo_key
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched)
      && $stable(out_param_digits) && $stable(out_echo_valid) && $stable(out_echo_key))
    else $error("result changed while stalled");

  // With no result pending the input side always takes a key
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result stage");

  // Digits only reported with a match
  a_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_param_digits == '0)
    else $error("digits reported without a match");

  // Echo key zero when not echoing; a match never comes with echo of a digit
  a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_echo_valid |-> out_echo_key == '0)
    else $error("echo key set without echo");

  a_echo_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_valid |-> out_param_digits == '0)
    else $error("echo in the digit phase");

endmodule

bind key_sequence_detector_unit ksd_checker u_ksd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_matched      (out_matched),
  .out_param_digits (out_param_digits),
  .out_echo_valid   (out_echo_valid),
  .out_echo_key     (out_echo_key)
);
